### src/tdc_pkg.sv
// Shared types and constants for the two-way data cache controller.
package tdc_pkg;

  localparam int unsigned TAG_W   = 21;
  localparam int unsigned TAG_LSB = 11;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned OFF_W   = 4;

  // controller_state output codes
  localparam logic [2:0] CODE_IDLE          = 3'd0;
  localparam logic [2:0] CODE_WAIT_BUF_READ = 3'd1;
  localparam logic [2:0] CODE_WAIT_MEM      = 3'd2;
  localparam logic [2:0] CODE_FILL          = 3'd3;
  localparam logic [2:0] CODE_WAIT_BUF_WR   = 3'd4;

  // per-set bookkeeping row
  typedef struct packed {
    logic             rep;
    logic             v1;
    logic [TAG_W-1:0] t1;
    logic             v0;
    logic [TAG_W-1:0] t0;
  } meta_t;

  // write strobes into the storage
  typedef struct packed {
    logic clear;
    logic meta;
    logic word0;
    logic word1;
  } we_t;

endpackage

### src/two_way_data_cache_controller_top.sv
// Two-way set-associative write-through cache controller, top level.
//
// One transaction is one cycle of the processor/memory interface: request
// flags, cpu address, store data, buffer full, memory ack, address and data.
// A transaction is taken on a rising edge with start high and busy low.
// The first cycle after that, tag/valid rows and the addressed words
// (already read on the accept edge) are compared, the controller steps and
// the read-modify-write goes back into the memories. The next cycle shows
// the result with done_o high for exactly that one cycle: load data, stall,
// buffer requests, hit flags and the controller state after the step.
// Busy is high while the step runs, so a new transaction is taken only once
// the result of the last one shows. Busy covers the read of the set memory
// followed by its write-back. After reset a clearing pass zeroes every set
// row, with busy high. The receiver cannot stall: each result is taken on
// the edge that ends its done_o cycle. The outputs hold between results.
module two_way_data_cache_controller_top import tdc_pkg::*; #(
  parameter int unsigned SET_COUNT  = 128,
  parameter int unsigned LINE_WORDS = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic              load_request_i,
  input  logic              store_request_i,
  input  logic              address_valid_i,
  input  logic [31:0]       cpu_address_i,
  input  logic [31:0]       store_data_i,
  input  logic              buffer_full_i,
  input  logic              memory_ack_i,
  input  logic [31:0]       memory_address_i,
  input  logic [31:0]       memory_data_i,
  output logic              done_o,
  output logic [31:0]       load_data_o,
  output logic              stall_res_o,
  output logic              buffer_data_valid_o,
  output logic              buffer_write_request_o,
  output logic              buffer_read_request_o,
  output logic              hit_way_zero_o,
  output logic              hit_way_one_o,
  output logic [2:0]        controller_state_o
);

  localparam int unsigned SetW  = $clog2(SET_COUNT);
  localparam int unsigned LaneW = $clog2(LINE_WORDS);
  localparam int unsigned CntW  = $clog2(LINE_WORDS + 1);

  // Transaction sequencer
  typedef enum logic [2:0] {
    SEQ_CLEAR = 3'b001,
    SEQ_READY = 3'b010,
    SEQ_EXEC  = 3'b100
  } seq_state_e;

  // Cache controller
  typedef enum logic [4:0] {
    CS_IDLE          = 5'b00001,
    CS_WAIT_BUF_READ = 5'b00010,
    CS_WAIT_MEM      = 5'b00100,
    CS_FILL          = 5'b01000,
    CS_WAIT_BUF_WR   = 5'b10000
  } cache_state_e;

  // set field (bits 10..4) reduced modulo SET_COUNT: binary restoring steps
  function automatic logic [SetW-1:0] set_of(input logic [31:0] a);
    logic [19:0] v;
    v = 20'(a[10:4]);
    for (int k = 6; k >= 0; k--) begin
      if (v >= 20'(SET_COUNT << k)) v = v - 20'(SET_COUNT << k);
    end
    return SetW'(v);
  endfunction

  // word within line, modulo LINE_WORDS (value below 4, one step suffices)
  function automatic logic [LaneW-1:0] lane_of(input logic [31:0] a);
    logic [4:0] v;
    v = 5'(a[3:2]);
    if (v >= 5'(LINE_WORDS)) v = v - 5'(LINE_WORDS);
    return LaneW'(v);
  endfunction

  function automatic logic [2:0] state_code(input cache_state_e s);
    logic [2:0] c;
    unique case (s)
      CS_IDLE:          c = CODE_IDLE;
      CS_WAIT_BUF_READ: c = CODE_WAIT_BUF_READ;
      CS_WAIT_MEM:      c = CODE_WAIT_MEM;
      CS_FILL:          c = CODE_FILL;
      CS_WAIT_BUF_WR:   c = CODE_WAIT_BUF_WR;
      default:          c = CODE_IDLE;
    endcase
    return c;
  endfunction

  seq_state_e   seq_q, seq_d;
  logic [SetW-1:0] clr_cnt_q, clr_cnt_d;
  logic         accept;

  // captured transaction
  logic         ld_q, st_q, av_q, full_q, ack_q;
  logic [31:0]  addr_q, sdata_q, maddr_q, mdata_q;

  // controller state
  cache_state_e cst_q, cst_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [OFF_W-1:0] last_q, last_d;
  logic [SetW-1:0]  fset_q, fset_d;
  logic [31:0]  held_q, held_d;
  logic         stall_q, stall_d;

  // result registers
  logic         done_q, dv_q, wb_q, rb_q, h0_q, h1_q;
  logic         dv, wb, rb;

  // storage interface
  we_t              we;
  logic [SetW-1:0]  wr_set;
  logic [LaneW-1:0] wr_lane;
  meta_t            wr_meta;
  logic [31:0]      wr_word;
  logic [SetW-1:0]  rd_set_b;
  meta_t            meta_a, meta_b;
  logic [31:0]      word0, word1;

  // decoded fields of the captured transaction
  logic [TAG_W-1:0] tag, mtag;
  logic [SetW-1:0]  set_a, mset;
  logic [LaneW-1:0] lane_a;
  logic             h0, h1, miss, req, way1;

  assign busy   = (seq_q != SEQ_READY);
  assign accept = start && !busy;

  // Second read port: the set being filled, or the fill word's set.
  assign rd_set_b = (cst_q == CS_FILL && !memory_ack_i) ? fset_q
                                                        : set_of(memory_address_i);

  tdc_mem #(
    .SET_COUNT (SET_COUNT),
    .LINE_WORDS(LINE_WORDS)
  ) u_mem (
    .clk_i      (clk_i),
    .we_i       (we),
    .wr_set_i   (wr_set),
    .wr_lane_i  (wr_lane),
    .wr_meta_i  (wr_meta),
    .wr_word_i  (wr_word),
    .rd_set_a_i (set_of(cpu_address_i)),
    .rd_lane_i  (lane_of(cpu_address_i)),
    .rd_set_b_i (rd_set_b),
    .rd_meta_a_o(meta_a),
    .rd_meta_b_o(meta_b),
    .rd_word0_o (word0),
    .rd_word1_o (word1)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ld_q    <= load_request_i;
      st_q    <= store_request_i;
      av_q    <= address_valid_i;
      addr_q  <= cpu_address_i;
      sdata_q <= store_data_i;
      full_q  <= buffer_full_i;
      ack_q   <= memory_ack_i;
      maddr_q <= memory_address_i;
      mdata_q <= memory_data_i;
    end
  end

  assign tag    = addr_q[31:TAG_LSB];
  assign mtag   = maddr_q[31:TAG_LSB];
  assign set_a  = set_of(addr_q);
  assign mset   = set_of(maddr_q);
  assign lane_a = lane_of(addr_q);
  assign h0     = meta_a.v0 && (meta_a.t0 == tag);
  assign h1     = meta_a.v1 && (meta_a.t1 == tag);
  assign miss   = !h0 && !h1;
  assign req    = (ld_q || st_q) && av_q;

  // sequencer
  always_comb begin
    seq_d     = seq_q;
    clr_cnt_d = clr_cnt_q;
    unique case (seq_q)
      SEQ_CLEAR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == SetW'(SET_COUNT - 1)) seq_d = SEQ_READY;
      end
      SEQ_READY: if (accept) seq_d = SEQ_EXEC;
      SEQ_EXEC:  seq_d = SEQ_READY;
      default:   seq_d = SEQ_CLEAR;
    endcase
  end

  // one controller step, with read-modify-write of the set rows
  always_comb begin
    cst_d   = cst_q;
    cnt_d   = cnt_q;
    last_d  = last_q;
    fset_d  = fset_q;
    stall_d = stall_q;
    held_d  = held_q;
    dv      = 1'b0;
    wb      = 1'b0;
    rb      = 1'b1;
    way1    = 1'b0;
    we      = '0;
    wr_set  = set_a;
    wr_lane = lane_a;
    wr_meta = meta_a;
    wr_word = sdata_q;

    // load hit updates the held word in every state, way one wins
    if (ld_q && h0) held_d = word0;
    if (ld_q && h1) held_d = word1;

    unique case (cst_q)
      CS_IDLE: begin
        wb = req && !full_q && miss;
        dv = req && !full_q;
        if (ld_q && av_q) begin
          if (miss) begin
            cst_d   = full_q ? CS_WAIT_BUF_READ : CS_WAIT_MEM;
            cnt_d   = '0;
            stall_d = 1'b1;
          end else begin
            stall_d = 1'b0;
          end
        end else if (st_q && av_q) begin
          if (full_q) begin
            cst_d   = CS_WAIT_BUF_WR;
            stall_d = 1'b1;
          end else begin
            stall_d = 1'b0;
          end
          if (miss) begin
            // allocate into the way picked by the replacement bit
            way1     = !meta_a.rep;
            we.word0 = !way1;
            we.word1 = way1;
            we.meta  = 1'b1;
            if (way1) begin
              wr_meta.t1 = tag;
              wr_meta.v1 = 1'b1;
            end else begin
              wr_meta.t0 = tag;
              wr_meta.v0 = 1'b1;
            end
          end else begin
            we.word0 = h0;
            we.word1 = !h0;
          end
        end
      end
      CS_WAIT_BUF_READ: begin
        if (!full_q) begin
          dv    = 1'b1;
          cnt_d = '0;
          cst_d = CS_WAIT_MEM;
        end
      end
      CS_WAIT_MEM: begin
        if (ack_q) begin
          // first fill word: word zero of the fill set, line made valid
          rb       = 1'b0;
          way1     = !meta_b.rep;
          wr_set   = mset;
          wr_lane  = '0;
          wr_word  = mdata_q;
          wr_meta  = meta_b;
          we.word0 = !way1;
          we.word1 = way1;
          we.meta  = 1'b1;
          if (way1) begin
            wr_meta.t1 = mtag;
            wr_meta.v1 = 1'b1;
          end else begin
            wr_meta.t0 = mtag;
            wr_meta.v0 = 1'b1;
          end
          cnt_d  = CntW'(1);
          last_d = maddr_q[OFF_W-1:0];
          fset_d = mset;
          cst_d  = CS_FILL;
        end else begin
          dv    = 1'b1;
          cnt_d = '0;
        end
      end
      CS_FILL: begin
        if (!ack_q) begin
          // fill over: flip the replacement bit of the filled set
          stall_d     = 1'b0;
          wr_set      = fset_q;
          wr_meta     = meta_b;
          wr_meta.rep = !meta_b.rep;
          we.meta     = 1'b1;
          cst_d       = CS_IDLE;
        end else if ({1'b0, maddr_q[OFF_W-1:0]} == {1'b0, last_q} + 5'd4) begin
          last_d = maddr_q[OFF_W-1:0];
          if (cnt_q < CntW'(LINE_WORDS)) begin
            way1     = !meta_b.rep;
            wr_set   = mset;
            wr_lane  = cnt_q[LaneW-1:0];
            wr_word  = mdata_q;
            we.word0 = !way1;
            we.word1 = way1;
            cnt_d    = cnt_q + 1'b1;
          end
        end
      end
      CS_WAIT_BUF_WR: begin
        if (!full_q) begin
          dv      = 1'b1;
          wb      = 1'b1;
          stall_d = 1'b0;
          cst_d   = CS_IDLE;
        end
      end
      default: cst_d = CS_IDLE;
    endcase

    // storage is touched only in the step cycle and by the clearing pass
    if (seq_q == SEQ_CLEAR) begin
      we       = '0;
      we.clear = 1'b1;
      wr_set   = clr_cnt_q;
    end else if (seq_q != SEQ_EXEC) begin
      we = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q     <= SEQ_CLEAR;
      clr_cnt_q <= '0;
      cst_q     <= CS_IDLE;
      cnt_q     <= '0;
      last_q    <= '0;
      fset_q    <= '0;
      held_q    <= '0;
      stall_q   <= 1'b0;
      done_q    <= 1'b0;
      dv_q      <= 1'b0;
      wb_q      <= 1'b0;
      rb_q      <= 1'b0;
      h0_q      <= 1'b0;
      h1_q      <= 1'b0;
    end else begin
      seq_q     <= seq_d;
      clr_cnt_q <= clr_cnt_d;
      done_q    <= (seq_q == SEQ_EXEC);
      if (seq_q == SEQ_EXEC) begin
        cst_q   <= cst_d;
        cnt_q   <= cnt_d;
        last_q  <= last_d;
        fset_q  <= fset_d;
        held_q  <= held_d;
        stall_q <= stall_d;
        dv_q    <= dv;
        wb_q    <= wb;
        rb_q    <= rb;
        h0_q    <= h0;
        h1_q    <= h1;
      end
    end
  end

  assign done_o                 = done_q;
  assign load_data_o            = held_q;
  assign stall_res_o            = stall_q;
  assign buffer_data_valid_o    = dv_q;
  assign buffer_write_request_o = wb_q;
  assign buffer_read_request_o  = rb_q;
  assign hit_way_zero_o         = h0_q;
  assign hit_way_one_o          = h1_q;
  assign controller_state_o     = state_code(cst_q);

endmodule

### src/tdc_mem.sv
// Set metadata memory and the two way data memories.
module tdc_mem import tdc_pkg::*; #(
  parameter int unsigned SET_COUNT  = 128,
  parameter int unsigned LINE_WORDS = 4
) (
  input  logic                          clk_i,
  input  we_t                           we_i,
  input  logic [$clog2(SET_COUNT)-1:0]  wr_set_i,
  input  logic [$clog2(LINE_WORDS)-1:0] wr_lane_i,
  input  meta_t                         wr_meta_i,
  input  logic [WORD_W-1:0]             wr_word_i,
  input  logic [$clog2(SET_COUNT)-1:0]  rd_set_a_i,
  input  logic [$clog2(LINE_WORDS)-1:0] rd_lane_i,
  input  logic [$clog2(SET_COUNT)-1:0]  rd_set_b_i,
  output meta_t                         rd_meta_a_o,
  output meta_t                         rd_meta_b_o,
  output logic [WORD_W-1:0]             rd_word0_o,
  output logic [WORD_W-1:0]             rd_word1_o
);

  meta_t                              meta_mem [SET_COUNT];
  logic [LINE_WORDS-1:0][WORD_W-1:0]  w0_mem   [SET_COUNT];
  logic [LINE_WORDS-1:0][WORD_W-1:0]  w1_mem   [SET_COUNT];

  always_ff @(posedge clk_i) begin
    if (we_i.clear) begin
      meta_mem[wr_set_i] <= '0;
    end else if (we_i.meta) begin
      meta_mem[wr_set_i] <= wr_meta_i;
    end
    rd_meta_a_o <= meta_mem[rd_set_a_i];
    rd_meta_b_o <= meta_mem[rd_set_b_i];
  end

  always_ff @(posedge clk_i) begin
    if (we_i.clear) begin
      w0_mem[wr_set_i] <= '0;
    end else if (we_i.word0) begin
      w0_mem[wr_set_i][wr_lane_i] <= wr_word_i;
    end
    rd_word0_o <= w0_mem[rd_set_a_i][rd_lane_i];
  end

  always_ff @(posedge clk_i) begin
    if (we_i.clear) begin
      w1_mem[wr_set_i] <= '0;
    end else if (we_i.word1) begin
      w1_mem[wr_set_i][wr_lane_i] <= wr_word_i;
    end
    rd_word1_o <= w1_mem[rd_set_a_i][rd_lane_i];
  end

endmodule
